@@ src/prd_pkg.sv @@
package prd_pkg;

   localparam int FRAC_BITS_OUT = 15;
   localparam int RSQRT_ITERATIONS = 3;
   localparam int COMP_BITS = 21;
   localparam int NORM_TOP = 29;
   localparam logic [31:0] GUESS_C0 = 32'd1181116006;
   localparam logic [31:0] GUESS_C1 = 32'd161061274;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [31:0] THREE_Q30 = 32'hC000_0000;

   localparam int CSR_ADDR_W = 6;
   typedef enum logic [2:0] {
      REG_WIDTH  = 3'd0,
      REG_HEIGHT = 3'd1,
      REG_FOCAL  = 3'd2,
      REG_RIGHT  = 3'd3,
      REG_UP     = 3'd4,
      REG_BACK   = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [15:0] sample_y;
      logic [15:0] sample_x;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] dir_z;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_x;
   } rsp_payload_type;

   // data that rides down the cell chain
   typedef struct packed {
      logic [31:0] t;
      logic [30:0] y;
      logic        odd;
      logic [2:0]  neg;
      logic [29:0] m0;
      logic [29:0] m1;
      logic [29:0] m2;
      logic        zero;
   } cell_data_type;

endpackage

@@ src/prd_cell.sv @@
// one Newton step of the inverse square root
module prd_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   valid_in,
   input  prd_pkg::cell_data_type data_in,
   output logic                   valid_out,
   output prd_pkg::cell_data_type data_out
);

   logic                   h_valid_ff, e_valid_ff, valid_ff;
   prd_pkg::cell_data_type h_data_ff, e_data_ff, data_ff;
   prd_pkg::cell_data_type stage_in;
   logic [31:0]            h_ff;
   logic [31:0]            e_ff;
   logic [62:0]            h_full;
   logic [62:0]            e_full;
   logic [31:0]            f_val;
   logic [62:0]            y_full;
   logic [31:0]            y_new;

   assign h_full = 63'(data_in.t) * 63'(data_in.y);
   assign e_full = 63'(h_ff) * 63'(h_data_ff.y);
   assign f_val  = (e_ff >= prd_pkg::THREE_Q30) ? 32'd0 : prd_pkg::THREE_Q30 - e_ff;
   assign y_full = 63'(e_data_ff.y) * 63'(f_val);
   assign y_new  = 32'(y_full >> 31);

   always_comb begin
      stage_in   = e_data_ff;
      stage_in.y = (y_new > 32'(prd_pkg::ONE_Q30)) ? prd_pkg::ONE_Q30 : y_new[30:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         h_valid_ff <= valid_in;
         e_valid_ff <= h_valid_ff;
         valid_ff   <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      h_data_ff <= data_in;
      h_ff      <= 32'(h_full >> 30);
      e_data_ff <= h_data_ff;
      e_ff      <= 32'(e_full >> 30);
      data_ff   <= stage_in;
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

@@ src/prd_front.sv @@
// centering, rotation, normalization shift, sum of squares, first guess
module prd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   valid_in,
   input  prd_pkg::req_payload_type req,
   input  logic [12:0]            image_width,
   input  logic [12:0]            image_height,
   input  logic [19:0]            focal_length,
   input  logic [62:0]            basis_right,
   input  logic [62:0]            basis_up,
   input  logic [62:0]            basis_back,
   output logic                   valid_out,
   output prd_pkg::cell_data_type data_out
);

   logic [6:0]          v_ff;
   logic signed [22:0]  cx_ff, cy_ff;
   logic signed [20:0]  cz_ff;
   logic signed [45:0]  pr_ff [3];
   logic signed [45:0]  pu_ff [3];
   logic signed [45:0]  pb_ff [3];
   logic signed [47:0]  w_ff [3];
   logic [46:0]         mag_ff [3];
   logic [2:0]          neg_ff, neg2_ff;
   logic [29:0]         m_ff [3];
   logic [59:0]         sq_ff [3];
   logic [2:0]          neg4_ff;
   logic [29:0]         m4_ff [3];
   logic                zero_ff, zero4_ff;
   logic [46:0]         maxm;
   logic [5:0]          p_val;
   logic [61:0]         s_val;
   logic                odd_val;
   logic [31:0]         t_val;
   logic [62:0]         g_prod;

   always_comb begin
      maxm = mag_ff[0];
      if (mag_ff[1] > maxm) maxm = mag_ff[1];
      if (mag_ff[2] > maxm) maxm = mag_ff[2];
      p_val = 6'd0;
      for (int i = 1; i < 47; i++) begin
         if (maxm[i]) p_val = 6'(i);
      end
   end

   assign s_val   = 62'(sq_ff[0]) + 62'(sq_ff[1]) + 62'(sq_ff[2]);
   assign odd_val = s_val[61:60] != 2'd0;
   assign t_val   = odd_val ? 32'(s_val >> 30) : 32'(s_val >> 28);
   assign g_prod  = 63'(t_val) * 63'(prd_pkg::GUESS_C1);

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else v_ff <= {v_ff[5:0], valid_in};
   end

   always_ff @(posedge clock) begin
      cx_ff <= 23'(({7'd0, req.sample_x} - {7'd0, image_width[12:1], 4'd0}) <<< 4);
      cy_ff <= 23'(({7'd0, image_height[12:1], 4'd0} - {7'd0, req.sample_y}) <<< 4);
      cz_ff <= -21'($signed({1'b0, focal_length}));
      for (int k = 0; k < 3; k++) begin
         pr_ff[k] <= 46'(cx_ff) * 46'($signed(basis_right[k*21 +: 21]));
         pu_ff[k] <= 46'(cy_ff) * 46'($signed(basis_up[k*21 +: 21]));
         pb_ff[k] <= 46'(cz_ff) * 46'($signed(basis_back[k*21 +: 21]));
         w_ff[k]  <= 48'(pr_ff[k]) + 48'(pu_ff[k]) + 48'(pb_ff[k]);
         mag_ff[k] <= w_ff[k][47] ? 47'(-w_ff[k]) : 47'(w_ff[k]);
         neg_ff[k] <= w_ff[k][47];
         if (p_val > 6'(prd_pkg::NORM_TOP))
            m_ff[k] <= 30'(mag_ff[k] >> (p_val - 6'(prd_pkg::NORM_TOP)));
         else
            m_ff[k] <= 30'(mag_ff[k] << (6'(prd_pkg::NORM_TOP) - p_val));
         sq_ff[k] <= 60'(m_ff[k]) * 60'(m_ff[k]);
         m4_ff[k] <= m_ff[k];
      end
      zero_ff  <= maxm == '0;
      neg2_ff  <= neg_ff;
      zero4_ff <= zero_ff;
      neg4_ff  <= neg2_ff;
      data_out.t    <= t_val;
      data_out.y    <= 31'(prd_pkg::GUESS_C0 - 32'(g_prod >> 30));
      data_out.odd  <= odd_val;
      data_out.neg  <= neg4_ff;
      data_out.m0   <= m4_ff[0];
      data_out.m1   <= m4_ff[1];
      data_out.m2   <= m4_ff[2];
      data_out.zero <= zero4_ff;
   end

   assign valid_out = v_ff[6];

endmodule

@@ src/prd_back.sv @@
// scaling, rounding, saturation
module prd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    valid_in,
   input  prd_pkg::cell_data_type  data_in,
   output logic                    valid_out,
   output prd_pkg::rsp_payload_type data_out
);

   localparam int SHIFT = 59 - prd_pkg::FRAC_BITS_OUT;

   logic [60:0]        prod_ff [3];
   logic [2:0]         neg_ff;
   logic               odd_ff, zero_ff, v_ff, v2_ff;
   logic [29:0]        m [3];
   logic signed [15:0] r [3];
   logic [61:0]        q;

   assign m[0] = data_in.m0;
   assign m[1] = data_in.m1;
   assign m[2] = data_in.m2;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         q = odd_ff ? ((62'(prod_ff[k]) + (62'd1 << SHIFT)) >> (SHIFT + 1))
                    : ((62'(prod_ff[k]) + (62'd1 << (SHIFT - 1))) >> SHIFT);
         if (zero_ff) r[k] = '0;
         else if (neg_ff[k]) r[k] = (q > 62'd32768) ? -16'sd32768 : 16'(-q);
         else r[k] = (q > 62'd32767) ? 16'sd32767 : 16'(q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v_ff  <= valid_in;
         v2_ff <= v_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) prod_ff[k] <= 61'(m[k]) * 61'(data_in.y);
      neg_ff  <= data_in.neg;
      odd_ff  <= data_in.odd;
      zero_ff <= data_in.zero;
      data_out.dir_x <= r[0];
      data_out.dir_y <= r[1];
      data_out.dir_z <= r[2];
   end

   assign valid_out = v2_ff;

endmodule

@@ src/pinhole_ray_direction.sv @@
// channel   direction  handshake       payload
// req       in         valid / stall   sample_x, sample_y (Q12.4)
// rsp       out        valid / stall   dir_x, dir_y, dir_z (Q1.15)
// csr       in         APB-style       six registers at 8*i
// One transaction per cycle while req_stall is low; each passes through the front,
// the Newton cells and the output scaling, and then through the output queue.
// Synchronous active-high reset clears valids and restores register defaults.
// req_stall rises while the output queue cannot absorb every transaction in flight.
module pinhole_ray_direction (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  prd_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output prd_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [prd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [63:0]              csr_pwdata,
   output logic [63:0]              csr_prdata,
   output logic                     csr_pready
);

   localparam int QD  = 32;
   localparam int QW  = $clog2(QD);

   logic [12:0] width_ff, height_ff;
   logic [19:0] focal_ff;
   logic [62:0] right_ff, up_ff, back_ff;
   logic        wr;
   prd_pkg::reg_index_type idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign idx = prd_pkg::reg_index_type'(csr_paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd640;
         height_ff <= 13'd480;
         focal_ff  <= 20'd148330;
         right_ff  <= 63'd1 << 19;
         up_ff     <= 63'd1 << 40;
         back_ff   <= 63'd1 << 61;
      end else if (wr && csr_paddr[2:0] == 3'd0) begin
         unique case (idx)
            prd_pkg::REG_WIDTH:  width_ff  <= csr_pwdata[12:0];
            prd_pkg::REG_HEIGHT: height_ff <= csr_pwdata[12:0];
            prd_pkg::REG_FOCAL:  focal_ff  <= csr_pwdata[19:0];
            prd_pkg::REG_RIGHT:  right_ff  <= csr_pwdata[62:0];
            prd_pkg::REG_UP:     up_ff     <= csr_pwdata[62:0];
            prd_pkg::REG_BACK:   back_ff   <= csr_pwdata[62:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         prd_pkg::REG_WIDTH:  csr_prdata = 64'(width_ff);
         prd_pkg::REG_HEIGHT: csr_prdata = 64'(height_ff);
         prd_pkg::REG_FOCAL:  csr_prdata = 64'(focal_ff);
         prd_pkg::REG_RIGHT:  csr_prdata = 64'(right_ff);
         prd_pkg::REG_UP:     csr_prdata = 64'(up_ff);
         prd_pkg::REG_BACK:   csr_prdata = 64'(back_ff);
         default:             csr_prdata = 64'd0;
      endcase
   end

   logic                   acc;
   logic                   f_valid;
   prd_pkg::cell_data_type f_data;
   logic                   c_valid [prd_pkg::RSQRT_ITERATIONS + 1];
   prd_pkg::cell_data_type c_data  [prd_pkg::RSQRT_ITERATIONS + 1];
   logic                   b_valid;
   prd_pkg::rsp_payload_type b_data;

   assign acc = req_valid && !req_stall;

   prd_front u_front (
      .clock, .reset, .valid_in(acc), .req(req_payload),
      .image_width(width_ff), .image_height(height_ff), .focal_length(focal_ff),
      .basis_right(right_ff), .basis_up(up_ff), .basis_back(back_ff),
      .valid_out(f_valid), .data_out(f_data)
   );

   assign c_valid[0] = f_valid;
   assign c_data[0]  = f_data;

   for (genvar i = 0; i < prd_pkg::RSQRT_ITERATIONS; i++) begin : g_cell
      prd_cell u_cell (
         .clock, .reset, .valid_in(c_valid[i]), .data_in(c_data[i]),
         .valid_out(c_valid[i+1]), .data_out(c_data[i+1])
      );
   end

   prd_back u_back (
      .clock, .reset, .valid_in(c_valid[prd_pkg::RSQRT_ITERATIONS]),
      .data_in(c_data[prd_pkg::RSQRT_ITERATIONS]),
      .valid_out(b_valid), .data_out(b_data)
   );

   // output queue sized for everything in flight
   prd_pkg::rsp_payload_type q_mem [QD];
   logic [QW-1:0] wp_ff, rp_ff;
   logic [QW:0]   cnt_ff, pend_ff;
   logic          pop;
   prd_pkg::rsp_payload_type rd_ff;
   logic          rv_ff;
   logic          load;

   assign load = (cnt_ff != '0) && (!rv_ff || !rsp_stall);
   assign pop  = rv_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (b_valid) q_mem[wp_ff] <= b_data;
      if (load) rd_ff <= q_mem[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         cnt_ff  <= '0;
         pend_ff <= '0;
         rv_ff   <= 1'b0;
      end else begin
         if (b_valid) wp_ff <= wp_ff + 1'b1;
         if (load) rp_ff <= rp_ff + 1'b1;
         cnt_ff  <= cnt_ff + (QW+1)'(b_valid) - (QW+1)'(load);
         pend_ff <= pend_ff + (QW+1)'(acc) - (QW+1)'(pop);
         if (load) rv_ff <= 1'b1;
         else if (pop) rv_ff <= 1'b0;
      end
   end

   assign req_stall   = pend_ff >= (QW+1)'(QD - 1);
   assign rsp_valid   = rv_ff;
   assign rsp_payload = rd_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QW+1)'(QD)) else $error("queue overflow");
   a_pend_ge: assert property (@(posedge clock) disable iff (reset)
      pend_ff >= cnt_ff) else $error("in-flight count below queue count");
   a_lat_pos: assert property (@(posedge clock) disable iff (reset)
      (pend_ff == '0) |-> !rsp_valid) else $error("result without transaction");
`endif

endmodule
